[rtl/core/mptc_pkg.sv]
package mptc_pkg;

   localparam int NUM_ENTRIES = 4;
   localparam int POS_WIDTH = 9;
   localparam int BLOCK_WIDTH = 33;
   localparam int CSR_INDEX_WIDTH = 8;

   // byte positions within sector zero
   localparam logic [POS_WIDTH-1:0] TABLE_FIRST_POS = 9'd446;
   localparam logic [POS_WIDTH-1:0] TABLE_LAST_POS = 9'd509;
   localparam logic [POS_WIDTH-1:0] SIG_LOW_POS = 9'd510;
   localparam logic [POS_WIDTH-1:0] SIG_HIGH_POS = 9'd511;

   localparam logic [7:0] SIG_LOW_BYTE = 8'h55;
   localparam logic [7:0] SIG_HIGH_BYTE = 8'hAA;

   localparam logic [7:0] TYPE_EMPTY = 8'h00;
   localparam logic [7:0] TYPE_PROTECTIVE = 8'hEE;
   localparam logic [7:0] TYPE_EXTENDED = 8'h05;
   localparam logic [7:0] TYPE_EXTENDED_LBA = 8'h0F;
   localparam logic [7:0] TYPE_EXTENDED_ALT = 8'h85;

   localparam logic [7:0] BOOT_NONE = 8'h00;
   localparam logic [7:0] BOOT_ACTIVE = 8'h80;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DISK_BLOCK_COUNT = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SECTOR_IS_512 = 8'd1;

   typedef enum logic [1:0] {
      STATUS_VALID = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_UNSUPPORTED = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] boot;
      logic [7:0] kind;
      logic [31:0] start;
      logic [31:0] length;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic sig_ok;
   } launch_type;

   typedef struct packed {
      logic empty;
      logic is_protective;
      logic extended;
      logic empty_bad;
      logic field_bad;
   } entry_flags_type;

endpackage

[rtl/core/mbr_partition_table_checker_top.sv]
// MBR partition table checker.
// req channel: one byte of sector zero per beat, in address order. req_first_byte
// marks byte zero and restarts the position count; without it the count runs on
// and wraps after byte 511.
// rsp channel: one verdict (status, protective) per sector, produced by the beat
// carrying byte 511. Other beats produce nothing.
// csr channel: index 0 writes disk_block_count, index 1 writes sector_is_512
// (bit 0). csr_ready is always high; write only while no verdict is pending.
// Throughput: one byte per cycle, except while byte 511 waits for a pending verdict.
// Byte 511 then passes the input register, extent sums, bound/overlap compares
// and the verdict register before rsp_valid rises.
// The rsp register decouples the sides: bytes keep flowing while a verdict waits.
// Only the next sector's byte 511 holds off (req_ready low) until the previous
// verdict has been taken.
// Reset clears the position count, the signature byte and all valid flags;
// disk_block_count resets to 0 and sector_is_512 to 1.
module mbr_partition_table_checker_top
   import mptc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_table_byte,
   input  logic                        req_first_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_protective,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [BLOCK_WIDTH-1:0]      csr_data
);

   logic [BLOCK_WIDTH-1:0]       disk_block_count_ff, disk_block_count_in;
   logic                         sector_is_512_ff, sector_is_512_in;
   logic                         judge_busy;
   launch_type                   launch;
   entry_type [NUM_ENTRIES-1:0]  entries;

   assign csr_ready = 1'b1;
   assign disk_block_count_in = (csr_valid && csr_index == CSR_DISK_BLOCK_COUNT)
      ? csr_data : disk_block_count_ff;
   assign sector_is_512_in = (csr_valid && csr_index == CSR_SECTOR_IS_512)
      ? csr_data[0] : sector_is_512_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_block_count_ff <= '0;
         sector_is_512_ff <= 1'b1;
      end else begin
         disk_block_count_ff <= disk_block_count_in;
         sector_is_512_ff <= sector_is_512_in;
      end
   end

   mptc_capture u_capture (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_table_byte (req_table_byte),
      .req_first_byte (req_first_byte),
      .judge_busy     (judge_busy),
      .launch         (launch),
      .entries        (entries)
   );

   mptc_judge u_judge (
      .clock            (clock),
      .reset            (reset),
      .launch           (launch),
      .entries          (entries),
      .disk_block_count (disk_block_count_ff),
      .sector_is_512    (sector_is_512_ff),
      .busy             (judge_busy),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_protective   (rsp_protective)
   );

endmodule

[rtl/core/mptc_capture.sv]
module mptc_capture
   import mptc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_table_byte,
   input  logic                         req_first_byte,
   input  logic                         judge_busy,
   output launch_type                   launch,
   output entry_type [NUM_ENTRIES-1:0]  entries
);

   localparam logic [3:0] FIELD_BOOT = 4'd0;
   localparam logic [3:0] FIELD_KIND = 4'd4;
   localparam logic [1:0] WORD_START = 2'd2;
   localparam logic [1:0] WORD_LENGTH = 2'd3;

   logic                        in_valid_ff, in_valid_in;
   logic [7:0]                  byte_ff;
   logic                        first_ff;
   logic [POS_WIDTH-1:0]        position_ff, position_in;
   logic [7:0]                  sig_low_ff, sig_low_in;
   entry_type [NUM_ENTRIES-1:0] entries_ff, entries_in;

   logic [POS_WIDTH-1:0]        pos;
   logic [POS_WIDTH-1:0]        table_offset;
   logic [1:0]                  slot;
   logic [3:0]                  field_byte;
   logic                        at_sig_high;
   logic                        in_table;
   logic                        advance;
   logic                        take;

   assign pos = first_ff ? '0 : position_ff;
   assign at_sig_high = (pos == SIG_HIGH_POS);
   assign in_table = (pos >= TABLE_FIRST_POS) && (pos <= TABLE_LAST_POS);
   assign table_offset = pos - TABLE_FIRST_POS;
   assign slot = table_offset[5:4];
   assign field_byte = table_offset[3:0];

   // the last byte waits here only while the previous verdict is still in flight
   assign advance = in_valid_ff && !(at_sig_high && judge_busy);
   assign req_ready = !in_valid_ff || advance;
   assign take = req_valid && req_ready;
   assign in_valid_in = take || (in_valid_ff && !advance);

   assign position_in = advance ? pos + 1'b1 : position_ff;
   assign sig_low_in = (advance && pos == SIG_LOW_POS) ? byte_ff : sig_low_ff;

   always_comb begin
      entries_in = entries_ff;
      if (advance && in_table) begin
         if (field_byte == FIELD_BOOT) begin
            entries_in[slot].boot = byte_ff;
         end else if (field_byte == FIELD_KIND) begin
            entries_in[slot].kind = byte_ff;
         end else if (field_byte[3:2] == WORD_START) begin
            entries_in[slot].start[{field_byte[1:0], 3'b000} +: 8] = byte_ff;
         end else if (field_byte[3:2] == WORD_LENGTH) begin
            entries_in[slot].length[{field_byte[1:0], 3'b000} +: 8] = byte_ff;
         end
      end
   end

   assign launch.valid = advance && at_sig_high;
   assign launch.sig_ok = (sig_low_ff == SIG_LOW_BYTE) && (byte_ff == SIG_HIGH_BYTE);
   assign entries = entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         position_ff <= '0;
         sig_low_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         position_ff <= position_in;
         sig_low_ff <= sig_low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_table_byte;
         first_ff <= req_first_byte;
      end
      entries_ff <= entries_in;
   end

endmodule

[rtl/core/mptc_judge.sv]
module mptc_judge
   import mptc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  launch_type                   launch,
   input  entry_type [NUM_ENTRIES-1:0]  entries,
   input  logic [BLOCK_WIDTH-1:0]       disk_block_count,
   input  logic                         sector_is_512,
   output logic                         busy,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_protective
);

   logic                                        s1_valid_ff, s1_sig_ok_ff;
   logic [NUM_ENTRIES-1:0][BLOCK_WIDTH-1:0]     ends_ff, ends_in;
   entry_flags_type [NUM_ENTRIES-1:0]           flags_ff, flags_in;

   logic                                        s2_valid_ff, s2_sig_ok_ff;
   entry_flags_type [NUM_ENTRIES-1:0]           flags2_ff;
   logic [NUM_ENTRIES-1:0]                      too_big_ff, too_big_in;
   logic [NUM_ENTRIES-1:0][NUM_ENTRIES-1:0]     overlap_ff, overlap_in;

   logic                                        rsp_valid_ff, rsp_valid_in;
   status_type                                  status_ff, status_in;
   logic                                        protective_ff, protective_in;

   // stage 1: end of each extent and per-entry flags
   always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         ends_in[i] = {1'b0, entries[i].start} + {1'b0, entries[i].length};
         flags_in[i].empty = (entries[i].kind == TYPE_EMPTY);
         flags_in[i].is_protective = (entries[i].kind == TYPE_PROTECTIVE);
         flags_in[i].extended = (entries[i].kind == TYPE_EXTENDED)
            || (entries[i].kind == TYPE_EXTENDED_LBA)
            || (entries[i].kind == TYPE_EXTENDED_ALT);
         flags_in[i].empty_bad = (entries[i].start != '0) || (entries[i].length != '0)
            || (entries[i].boot != BOOT_NONE);
         flags_in[i].field_bad = ((entries[i].boot != BOOT_NONE)
               && (entries[i].boot != BOOT_ACTIVE))
            || (entries[i].start == '0) || (entries[i].length == '0);
      end
   end

   // stage 2: disk bound and pairwise overlap against earlier entries
   always_comb begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         too_big_in[i] = (ends_ff[i] > disk_block_count);
         for (int j = 0; j < NUM_ENTRIES; j++) begin
            overlap_in[i][j] = (j < i)
               && ({1'b0, entries[i].start} < ends_ff[j])
               && ({1'b0, entries[j].start} < ends_ff[i]);
         end
      end
   end

   // stage 3: first failing check, or a protective entry, decides
   always_comb begin
      logic done;
      logic any_protective;
      done = 1'b0;
      any_protective = 1'b0;
      status_in = STATUS_VALID;
      protective_in = 1'b0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         any_protective = any_protective | flags2_ff[i].is_protective;
      end
      if (!s2_sig_ok_ff) begin
         status_in = STATUS_INVALID;
         done = 1'b1;
      end else if (any_protective) begin
         protective_in = 1'b1;
         done = 1'b1;
      end else if (!sector_is_512) begin
         status_in = STATUS_UNSUPPORTED;
         done = 1'b1;
      end
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (!done) begin
            if (flags2_ff[i].empty) begin
               if (flags2_ff[i].empty_bad) begin
                  status_in = STATUS_INVALID;
                  done = 1'b1;
               end
            end else if (flags2_ff[i].extended) begin
               status_in = STATUS_UNSUPPORTED;
               done = 1'b1;
            end else if (flags2_ff[i].field_bad || too_big_ff[i]) begin
               status_in = STATUS_INVALID;
               done = 1'b1;
            end else begin
               for (int j = 0; j < NUM_ENTRIES; j++) begin
                  if (overlap_ff[i][j] && !flags2_ff[j].empty) begin
                     status_in = STATUS_INVALID;
                     done = 1'b1;
                  end
               end
            end
         end
      end
   end

   assign rsp_valid_in = s2_valid_ff || (rsp_valid_ff && !rsp_ready);
   assign busy = s1_valid_ff || s2_valid_ff || rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_protective = protective_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= launch.valid;
         s2_valid_ff <= s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sig_ok_ff <= launch.sig_ok;
      ends_ff <= ends_in;
      flags_ff <= flags_in;
      s2_sig_ok_ff <= s1_sig_ok_ff;
      flags2_ff <= flags_ff;
      too_big_ff <= too_big_in;
      overlap_ff <= overlap_in;
      if (s2_valid_ff) begin
         status_ff <= status_in;
         protective_ff <= protective_in;
      end
   end

   a_one_verdict: assert property (@(posedge clock) disable iff (reset)
      $onehot0({s1_valid_ff, s2_valid_ff, rsp_valid_ff}))
      else $error("more than one verdict in flight");

   a_launch_idle: assert property (@(posedge clock) disable iff (reset)
      launch.valid |-> !busy)
      else $error("verdict launched while judge busy");

   a_stage_flow: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> s2_valid_ff && !rsp_valid_ff)
      else $error("stage 1 verdict lost");

   a_protective_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && protective_ff |-> status_ff == STATUS_VALID)
      else $error("protective verdict without valid status");

endmodule
